// ----- rtl/lbcg_pkg.sv -----
// ----------------------------------------------------------------------------
// lbcg_pkg: shared constants for the LED blink code generator
// Field widths, operation and register index codes, timing defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lbcg_pkg;

    // field and state widths
    localparam int CODE_BITS = 8;
    localparam int PASS_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int OP_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    // stream word widths (packed fields, padded to whole bytes)
    localparam int S_TDATA_BITS = 40;  // now, status_code
    localparam int M_TDATA_BITS = 24;  // led, active, times_shown, zero pad

    // acceptance window after a scheduled event, in timer counts
    localparam logic [TIME_BITS-1:0] LATE_WINDOW = 32'd1000000;

    // register reset values
    localparam logic [TIME_BITS-1:0] ON_TIME_RST   = 32'd20000000;
    localparam logic [TIME_BITS-1:0] DARK_TIME_RST = 32'd35000000;
    localparam logic [TIME_BITS-1:0] GAP_TIME_RST  = 32'd125000000;

    localparam logic [PASS_BITS-1:0] PASS_MAX = {PASS_BITS{1'b1}};

    // operation codes
    localparam logic [OP_BITS-1:0] OP_SAMPLE      = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SET         = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SET_CHANGED = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ON_TIME   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DARK_TIME = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_TIME  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/led_blink_code_generator.sv -----
// ----------------------------------------------------------------------------
// led_blink_code_generator: shows a status code as LED pulse trains
// Each input word carries a timer sample or a status update; each one
// produces one output word with the LED level and pass count.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per item. s_tuser holds the operation (sample,
//   set status, set status if changed); s_tdata holds the timer value and
//   the status code. m_ channel: one word per accepted item with the LED
//   level, the active flag and the number of completed code repeats.
//   cfg channel: writes the lit, dark and gap times (index 0, 1, 2);
//   other indexes are ignored. Write only while the block is idle.
//   An accepted item is held in the input register and then loaded into
//   the output register, which drives m_.
//   Throughput: one item per cycle while m_ is not stalled; the state
//   update for an item is a single add, window compare and counter step
//   done between the input register and the output register.
//   Reset (aresetn low, synchronous): both stages empty, LED dark, code
//   cleared, timing registers back to their defaults.
//   Stall: with m_tready low the output word holds; one more item can be
//   taken into the input register, after which s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_code_generator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [31:0] now, [39:32] status_code
    input  wire logic [lbcg_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // [1:0] operation
    input  wire logic [lbcg_pkg::OP_BITS-1:0]        s_tuser,
    // result stream
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [0] led, [1] active, [17:2] times_shown, [23:18] zero
    output      logic [lbcg_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // configuration writes
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [lbcg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [lbcg_pkg::TIME_BITS-1:0]      cfg_data
);
    import lbcg_pkg::*;

    // timing registers
    logic [TIME_BITS-1:0] on_time_reg;
    logic [TIME_BITS-1:0] dark_time_reg;
    logic [TIME_BITS-1:0] gap_time_reg;

    // input stage
    logic                 in_valid_reg;
    logic [OP_BITS-1:0]   op_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CODE_BITS-1:0] status_reg;

    // sequence state
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic                 enabled_reg, enabled_next;
    logic [CODE_BITS-1:0] pulse_count_reg, pulse_count_next;
    logic                 lit_reg, lit_next;
    logic [TIME_BITS-1:0] next_event_reg, next_event_next;
    logic [PASS_BITS-1:0] pass_count_reg, pass_count_next;

    // output stage
    logic                 out_valid_reg;
    logic                 led_reg, active_reg;
    logic [PASS_BITS-1:0] shown_reg, shown_next;

    logic                 advance;
    logic                 proc;
    logic [TIME_BITS-1:0] win_offset;
    logic                 in_window;
    logic                 do_set;

    // handshake
    assign advance   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // event window, wrap-safe
    assign win_offset = next_event_reg + LATE_WINDOW - now_reg;
    assign in_window  = (win_offset <= LATE_WINDOW);
    assign do_set    = (op_reg == OP_SET) ||
                       ((op_reg == OP_SET_CHANGED) && (status_reg != code_reg));

    // next-state logic for one item
    always_comb begin
        code_next        = code_reg;
        enabled_next     = enabled_reg;
        pulse_count_next = pulse_count_reg;
        lit_next         = lit_reg;
        next_event_next  = next_event_reg;
        pass_count_next  = pass_count_reg;
        if (do_set) begin
            code_next        = status_reg;
            lit_next         = 1'b0;
            pulse_count_next = '0;
            pass_count_next  = '0;
            enabled_next     = (status_reg != '0);
            if (status_reg != '0) begin
                next_event_next = now_reg + gap_time_reg;
            end
        end else if (op_reg == OP_SAMPLE && enabled_reg && in_window) begin
            if (lit_reg) begin
                lit_next = 1'b0;
                if (pulse_count_reg == code_reg) begin
                    next_event_next  = next_event_reg + gap_time_reg;
                    pulse_count_next = '0;
                end else begin
                    next_event_next = next_event_reg + dark_time_reg;
                end
            end else begin
                lit_next = 1'b1;
                if (pulse_count_reg == '0 && pass_count_reg != PASS_MAX) begin
                    pass_count_next = pass_count_reg + 1'b1;
                end
                next_event_next  = next_event_reg + on_time_reg;
                pulse_count_next = pulse_count_reg + 1'b1;
            end
        end
        shown_next = (pass_count_next == '0) ? '0 : pass_count_next - 1'b1;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_time_reg   <= ON_TIME_RST;
            dark_time_reg <= DARK_TIME_RST;
            gap_time_reg  <= GAP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ON_TIME:   on_time_reg   <= cfg_data;
                REG_DARK_TIME: dark_time_reg <= cfg_data;
                REG_GAP_TIME:  gap_time_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            code_reg        <= '0;
            enabled_reg     <= 1'b0;
            pulse_count_reg <= '0;
            lit_reg         <= 1'b0;
            next_event_reg  <= '0;
            pass_count_reg  <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (proc) begin
                code_reg        <= code_next;
                enabled_reg     <= enabled_next;
                pulse_count_reg <= pulse_count_next;
                lit_reg         <= lit_next;
                next_event_reg  <= next_event_next;
                pass_count_reg  <= pass_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            op_reg     <= s_tuser;
            now_reg    <= s_tdata[TIME_BITS-1:0];
            status_reg <= s_tdata[TIME_BITS +: CODE_BITS];
        end
        if (proc) begin
            led_reg    <= lit_next && enabled_next;
            active_reg <= enabled_next;
            shown_reg  <= shown_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-PASS_BITS-2){1'b0}}, shown_reg, active_reg, led_reg};

    // a dark code never has a lit LED
    a_dark_when_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> !lit_reg)
        else $error("LED lit while disabled");

    // counters are cleared whenever blinking is off
    a_counts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !enabled_reg |-> (pass_count_reg == '0 && pulse_count_reg == '0))
        else $error("counters not cleared while disabled");

    // a status write restarts the pass count
    a_set_clears_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && op_reg == OP_SET) |=> (pass_count_reg == '0 && !lit_reg))
        else $error("set status did not restart the sequence");

    // a held input word is not lost under stall
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a word");

    // state only moves when an item is processed
    a_state_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (!proc && !cfg_valid) |=> ($stable(next_event_reg) && $stable(lit_reg)))
        else $error("state changed without an item");

endmodule

`default_nettype wire

// ----- dv/tb_led_blink_code_generator.sv -----
// ----------------------------------------------------------------------------
// tb_led_blink_code_generator: self-checking bench for the LED blink coder
// Drives timer samples and status updates with bursty input and a stalling
// output side, predicts every result word from a behavioral copy of the
// blink sequencer, and checks LED level, active flag, repeat count and zero pad.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_led_blink_code_generator;

    import lbcg_pkg::*;

    // codes with no name in the package
    localparam logic [OP_BITS-1:0]      OP_RESERVED = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED  = 2'd3;

    localparam int DRAIN_CYCLES = 4;      // pipeline is two stages deep
    localparam int LONG_HOLD    = 64;     // output stall for the fill test
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        logic                 led;
        logic                 active;
        logic [PASS_BITS-1:0] shown;
    } blink_out_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [OP_BITS-1:0]      s_tuser  = OP_SAMPLE;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_ON_TIME;
    logic [TIME_BITS-1:0]    cfg_data  = '0;

    // predicted sequencer state and timing registers
    logic [TIME_BITS-1:0] on_len  = ON_TIME_RST;
    logic [TIME_BITS-1:0] off_len = DARK_TIME_RST;
    logic [TIME_BITS-1:0] gap_len = GAP_TIME_RST;
    logic [CODE_BITS-1:0] blink_code = '0;
    logic                 blink_on   = 1'b0;
    logic [CODE_BITS-1:0] pulse_idx  = '0;
    logic                 led_lit    = 1'b0;
    logic [TIME_BITS-1:0] due_time   = '0;
    logic [PASS_BITS-1:0] passes     = '0;

    blink_out_t expected_q[$];

    int errors       = 0;
    int words_sent   = 0;
    int results_seen = 0;
    int led_edges    = 0;
    int reg_writes   = 0;
    int unsigned cycles = 0;

    // sender burst control
    int burst_left = 0;
    bit gaps_on    = 1'b1;

    // long-hold request to the receiver, counted there
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;
    int unsigned rx_cycle = 0;

    led_blink_code_generator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [31:0] now, [39:32] status_code
        .s_tuser   (s_tuser),    // [1:0] operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [0] led, [1] active, [17:2] times_shown
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // status update: re-arm with the first pulse one gap from now
    function automatic void load_status(input logic [CODE_BITS-1:0] status,
                                        input logic [TIME_BITS-1:0] now);
        blink_code = status;
        led_lit    = 1'b0;
        blink_on   = (status != '0);
        if (status != '0)
            due_time = now + gap_len;
        pulse_idx = '0;
        passes    = '0;
    endfunction

    task automatic step_blinker(input logic [OP_BITS-1:0] op,
                                input logic [TIME_BITS-1:0] now,
                                input logic [CODE_BITS-1:0] status,
                                output blink_out_t r);
        logic [TIME_BITS-1:0] slack;
        case (op)
            OP_SAMPLE: begin
                // wrap-safe window: now in [due, due + LATE_WINDOW]
                slack = due_time + LATE_WINDOW - now;
                if (blink_on && slack <= LATE_WINDOW) begin
                    led_edges++;
                    if (led_lit) begin
                        if (pulse_idx == blink_code) begin
                            due_time  = due_time + gap_len;
                            pulse_idx = '0;
                        end else begin
                            due_time = due_time + off_len;
                        end
                        led_lit = 1'b0;
                    end else begin
                        if (pulse_idx == '0 && passes != PASS_MAX)
                            passes = passes + 1'b1;
                        due_time  = due_time + on_len;
                        pulse_idx = pulse_idx + 1'b1;
                        led_lit   = 1'b1;
                    end
                end
            end
            OP_SET: load_status(status, now);
            OP_SET_CHANGED: begin
                if (status != blink_code)
                    load_status(status, now);
            end
            default: ;
        endcase
        r.led    = led_lit && blink_on;
        r.active = blink_on;
        r.shown  = (passes == '0) ? '0 : passes - 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // send one word; bursts of random length separated by random gaps
    task automatic send_item(input logic [OP_BITS-1:0] op,
                             input logic [TIME_BITS-1:0] now,
                             input logic [CODE_BITS-1:0] status);
        int gap;
        blink_out_t want;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {status, now};
        do @(posedge aclk); while (!s_tready);
        step_blinker(op, now, status, want);
        expected_q.push_back(want);
        words_sent++;
    endtask

    // sample relative to the next scheduled event
    task automatic sample_at(input logic [TIME_BITS-1:0] offset);
        send_item(OP_SAMPLE, due_time + offset, CODE_BITS'($urandom));
    endtask

    // mostly event hits, some window edges and misses, a few status updates
    task automatic send_random_item();
        logic [OP_BITS-1:0]   op;
        logic [TIME_BITS-1:0] now;
        logic [CODE_BITS-1:0] status;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 88)      op = OP_SAMPLE;
        else if (pick < 93) op = OP_SET;
        else if (pick < 98) op = OP_SET_CHANGED;
        else                op = OP_RESERVED;

        pick = $urandom_range(0, 9);
        if (pick < 6)       status = CODE_BITS'($urandom_range(1, 3));
        else if (pick == 6) status = '0;
        else if (pick == 7) status = blink_code;
        else                status = CODE_BITS'($urandom);

        pick = $urandom_range(0, 9);
        if (pick < 6)       now = due_time + $urandom_range(0, LATE_WINDOW);
        else if (pick == 6) now = due_time - $urandom_range(1, 1000);
        else if (pick == 7) now = due_time + LATE_WINDOW + $urandom_range(1, 1000);
        else                now = $urandom;
        send_item(op, now, status);
    endtask

    task automatic stop_sending();
        s_tvalid   <= 1'b0;
        burst_left = 0;
    endtask

    // let every expected word come back before touching registers
    task automatic quiesce();
        stop_sending();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [TIME_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_ON_TIME:   on_len  = val;
            REG_DARK_TIME: off_len = val;
            REG_GAP_TIME:  gap_len = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic program_timing(input logic [TIME_BITS-1:0] on_val,
                                  input logic [TIME_BITS-1:0] off_val,
                                  input logic [TIME_BITS-1:0] gap_val);
        quiesce();
        write_reg(REG_ON_TIME, on_val);
        write_reg(REG_DARK_TIME, off_val);
        write_reg(REG_GAP_TIME, gap_val);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // default timing: idle behavior, window edges, one full code, updates
    task automatic test_directed_sequence();
        send_item(OP_SAMPLE, '0, '0);
        send_item(OP_SAMPLE, '1, 8'hFF);
        send_item(OP_RESERVED, 32'h1234_5678, 8'hFF);
        // arm near the top of the timer so the schedule wraps
        send_item(OP_SET, 32'hFFFF_FFF0, 8'd2);
        sample_at(-1);
        sample_at(LATE_WINDOW + 1);
        sample_at(LATE_WINDOW);          // late edge of the window: lights
        sample_at(0);                    // dark, then off time
        sample_at(LATE_WINDOW / 2);      // second pulse
        sample_at(0);                    // last pulse done, gap follows
        sample_at(-LATE_WINDOW);
        sample_at(0);                    // second pass starts
        sample_at(0);
        send_item(OP_RESERVED, due_time, 8'd7);
        send_item(OP_SET_CHANGED, 32'h0000_0100, 8'd2);   // same code
        send_item(OP_SET_CHANGED, 32'h8000_0000, 8'd3);   // new code re-arms
        sample_at(0);
        send_item(OP_SET, 32'h0000_0042, 8'd0);           // disable
        sample_at(0);
        send_item(OP_SET_CHANGED, 32'h0000_0001, 8'd0);   // still zero
        send_item(OP_SET, '0, 8'hFF);                     // largest code
        sample_at(0);
        send_item(OP_SET, 32'h7FFF_FFFF, 8'h80);
        sample_at(0);
    endtask

    // zero and all-ones timing, plus a write to an unmapped index
    task automatic test_register_extremes();
        program_timing('0, '0, '0);
        send_item(OP_SET, $urandom, 8'd1);
        repeat (5) sample_at(0);
        repeat (20) send_random_item();

        program_timing('1, '1, '1);
        send_item(OP_SET, $urandom, 8'd2);
        repeat (6) sample_at(0);
        repeat (20) send_random_item();

        quiesce();
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        cfg_valid <= 1'b0;
        repeat (10) send_random_item();
    endtask

    // random traffic under several timing settings
    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: program_timing($urandom_range(1, 200000000),
                                  $urandom_range(1, 200000000),
                                  $urandom_range(1, 200000000));
                1: program_timing($urandom_range(0, 2 * LATE_WINDOW),
                                  $urandom_range(0, 2 * LATE_WINDOW),
                                  $urandom_range(0, 2 * LATE_WINDOW));
                2: program_timing(32'hFFFF_FFFF - $urandom_range(0, LATE_WINDOW),
                                  32'hFFFF_FFFF - $urandom_range(0, LATE_WINDOW),
                                  32'hFFFF_FFFF - $urandom_range(0, LATE_WINDOW));
                default: program_timing($urandom, $urandom, $urandom);
            endcase
            repeat (120) send_random_item();
        end
    endtask

    // output held off for a long stretch while input keeps coming
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req <= hold_req + 1;
        repeat (40) send_random_item();
        gaps_on = 1'b1;
    endtask

    // run a one-pulse code through a run of back-to-back passes
    task automatic test_repeated_passes();
        program_timing(32'd10, 32'd10, 32'd10);
        gaps_on = 1'b0;
        send_item(OP_SET, $urandom, 8'd1);
        repeat (24) sample_at(0);
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern chosen by rx_cycle[10:9]; long hold on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            case (rx_cycle[10:9])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= (rx_cycle % 3 != 0);
                default: m_tready <= ($urandom_range(0, 9) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expected word
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        blink_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected: %h", $time, m_tdata);
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (m_tdata[0] !== want.led) begin
                    errors++;
                    $display("%0t: led expected %0b actual %0b",
                             $time, want.led, m_tdata[0]);
                end
                if (m_tdata[1] !== want.active) begin
                    errors++;
                    $display("%0t: active expected %0b actual %0b",
                             $time, want.active, m_tdata[1]);
                end
                if (m_tdata[17:2] !== want.shown) begin
                    errors++;
                    $display("%0t: times_shown expected %0d actual %0d",
                             $time, want.shown, m_tdata[17:2]);
                end
                if (m_tdata[23:18] !== 6'd0) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %h",
                             $time, m_tdata[23:18]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding",
                     $time, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sequence();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_repeated_passes();

        quiesce();
        repeat (8) @(posedge aclk);
        $display("Covered %0d words in, %0d results checked, %0d LED transitions,",
                 words_sent, results_seen, led_edges);
        $display("%0d register writes incl. zero, all-ones and unmapped index; %s",
                 reg_writes, "long output hold and repeated code passes");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
